@@ src/gra_pkg.sv @@
// ----------------------------------------------------------------------------
// gra_pkg: shared definitions for the gain ramp core
// Fixed-point widths, gain constants, register indexes and the control states.
// ----------------------------------------------------------------------------
package gra_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int TIME_W         = 32;
    localparam int SPAN_W         = 16;
    localparam int PROD_W         = GAIN_W + SPAN_W;

    localparam int S_TDATA_W = ((1 + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((GAIN_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [GAIN_W-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam int EPS_INT = ((1 << GAIN_FRAC_BITS) * 2) / 1000;
    localparam logic [GAIN_W-1:0] EPS = GAIN_W'(EPS_INT);
    localparam logic [GAIN_W-1:0] SNAP_LEVEL = UNITY - EPS;

    localparam logic [CFG_ADDR_W-1:0] CFG_DUCK    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_FINISH
    } gra_state_t;

endpackage

@@ src/gra_mul.sv @@
// ----------------------------------------------------------------------------
// gra_mul: bit-serial multiplier
// Shift-add product of the gain delta and the elapsed time, one multiplier
// bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module gra_mul
    import gra_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [GAIN_W-1:0] multiplicand,
    input  logic [SPAN_W-1:0] multiplier,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(SPAN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPAN_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0] mcand_reg;
    logic [GAIN_W-1:0] hi_reg;
    logic [SPAN_W-1:0] lo_reg;
    logic [GAIN_W:0]   sum;

    // The partial sum shifts right into the low half as the multiplier shifts out.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= multiplicand;
            hi_reg    <= '0;
            lo_reg    <= multiplier;
        end else if (busy_reg) begin
            hi_reg <= sum[GAIN_W:1];
            lo_reg <= {sum[0], lo_reg[SPAN_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

@@ src/gra_div.sv @@
// ----------------------------------------------------------------------------
// gra_div: bit-serial restoring divider
// Divides the scaled delta by the ramp duration, one quotient bit per cycle.
// The quotient is known to fit the gain width, so only those bits are formed.
// ----------------------------------------------------------------------------
module gra_div
    import gra_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [GAIN_W-1:0] quotient
);

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SPAN_W-1:0] dsor_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [GAIN_W-1:0] q_reg;
    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              fits;

    // Dividend bits leave the top of q_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, q_reg[GAIN_W-1]};
    assign diff  = trial - {1'b0, dsor_reg};
    assign fits  = trial >= {1'b0, dsor_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dsor_reg <= divisor;
            rem_reg  <= dividend[PROD_W-1:GAIN_W];
            q_reg    <= dividend[GAIN_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            q_reg   <= {q_reg[GAIN_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ src/gain_ramp_attack_release_core.sv @@
// Processing: a reset command, a first update or a finished ramp goes from the
// input transfer through the evaluate, decide and finish states to the result;
// a ramp in progress also passes the 16-step serial multiplier and the 17-step serial divider.
// Flow: a new item is accepted only after the previous result has been loaded into the output register.
// Reset: synchronous, active low; clears control, registers and ramp state.
// ----------------------------------------------------------------------------
// gain_ramp_attack_release_core: linear attack/release gain ramp
// Tracks a ducking gain between the duck factor and unity and reports the
// interpolated gain for every timestamp transfer.
// ----------------------------------------------------------------------------
module gain_ramp_attack_release_core
    import gra_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] voice_active, [32:1] now_ms, rest zero
    input  logic                  s_tuser,   // [0] command
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [16:0] gain, rest zero
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gra_state_t state_reg, state_next;

    logic [GAIN_W-1:0] duck_reg;
    logic [SPAN_W-1:0] attack_reg;
    logic [SPAN_W-1:0] release_reg;

    logic              ready_reg;
    logic [GAIN_W-1:0] current_reg;
    logic [GAIN_W-1:0] origin_reg;
    logic [GAIN_W-1:0] goal_reg;
    logic [TIME_W-1:0] origin_time_reg;
    logic [SPAN_W-1:0] span_reg;

    logic              cmd_reg;
    logic              voice_reg;
    logic [TIME_W-1:0] now_reg;
    logic              down_reg;
    logic [GAIN_W-1:0] g1_reg;
    logic [GAIN_W-1:0] final_reg;
    logic              restart_reg;

    logic              m_tvalid_reg;
    logic [GAIN_W-1:0] m_gain_reg;

    logic              mul_start, mul_done;
    logic [PROD_W-1:0] mul_product;
    logic              div_start, div_done;
    logic [GAIN_W-1:0] div_quotient;

    logic [GAIN_W-1:0] duck_clamped;
    logic [GAIN_W-1:0] target;
    logic [SPAN_W-1:0] dur;
    logic [TIME_W-1:0] elapsed;
    logic              at_goal;
    logic              going_down;
    logic [GAIN_W-1:0] delta;
    logic [GAIN_W-1:0] gap;
    logic              restart;
    logic [GAIN_W-1:0] pick;
    logic [GAIN_W-1:0] decided;
    logic              out_free;
    logic              in_xfer;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign duck_clamped = (duck_reg > UNITY) ? UNITY : duck_reg;
    assign target       = voice_reg ? duck_clamped : UNITY;
    assign dur          = voice_reg ? attack_reg : release_reg;

    assign elapsed    = now_reg - origin_time_reg;
    assign at_goal    = (span_reg == '0) ||
                        (elapsed >= {{(TIME_W-SPAN_W){1'b0}}, span_reg});
    assign going_down = goal_reg < origin_reg;
    assign delta      = going_down ? origin_reg - goal_reg : goal_reg - origin_reg;

    assign gap     = (target >= goal_reg) ? target - goal_reg : goal_reg - target;
    assign restart = !ready_reg || (gap > EPS) || (dur != span_reg);
    // A restarted ramp sits at its origin at time zero, unless it has no length.
    assign pick    = (restart && dur == '0) ? target : g1_reg;
    assign decided = cmd_reg ? UNITY :
                     (!voice_reg && pick >= SNAP_LEVEL) ? UNITY : pick;

    gra_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplicand (delta),
        .multiplier   (elapsed[SPAN_W-1:0]),
        .done         (mul_done),
        .product      (mul_product)
    );

    gra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (cmd_reg || !ready_reg || at_goal) begin
                    state_next = ST_DECIDE;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duck_reg    <= UNITY;
            attack_reg  <= '0;
            release_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_DUCK:    duck_reg    <= cfg_data;
                CFG_ATTACK:  attack_reg  <= cfg_data[SPAN_W-1:0];
                CFG_RELEASE: release_reg <= cfg_data[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg   <= s_tuser;
            voice_reg <= s_tdata[0];
            now_reg   <= s_tdata[TIME_W:1];
        end
        if (state_reg == ST_EVAL) begin
            down_reg <= going_down;
            g1_reg   <= ready_reg ? goal_reg : current_reg;
        end
        if (state_reg == ST_DIV && div_done) begin
            g1_reg <= down_reg ? origin_reg - div_quotient : origin_reg + div_quotient;
        end
        if (state_reg == ST_DECIDE) begin
            final_reg   <= decided;
            restart_reg <= restart;
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_gain_reg <= final_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg       <= 1'b0;
            current_reg     <= UNITY;
            origin_reg      <= UNITY;
            goal_reg        <= UNITY;
            origin_time_reg <= '0;
            span_reg        <= '0;
        end else if (state_reg == ST_FINISH && out_free) begin
            if (cmd_reg) begin
                ready_reg   <= 1'b0;
                current_reg <= UNITY;
                origin_reg  <= UNITY;
                goal_reg    <= UNITY;
                span_reg    <= '0;
            end else begin
                ready_reg   <= 1'b1;
                current_reg <= final_reg;
                if (restart_reg) begin
                    origin_reg      <= g1_reg;
                    goal_reg        <= target;
                    origin_time_reg <= now_reg;
                    span_reg        <= dur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-GAIN_W){1'b0}}, m_gain_reg};

`ifndef SYNTHESIS
    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside the multiply state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_gain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[GAIN_W-1:0] <= UNITY)
        else $error("result gain above unity");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> m_tvalid && state_reg == ST_IDLE)
        else $error("finished item did not reach the output register");
`endif

endmodule
